>>> rtl/imbm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imbm_pkg: shared types and constants of the IP/MAC binding monitor
// Event codes, default sizes and the reset value of the activity gap.
// ---------------------------------------------------------------------------
package imbm_pkg;

    localparam int unsigned BUCKETS_DEF     = 1024;
    localparam int unsigned WAYS_DEF        = 4;
    localparam int unsigned MACS_PER_IP_DEF = 4;
    localparam int unsigned TIME_BITS_DEF   = 32;

    localparam logic [31:0] DELTA_RESET = 32'd15552000;

    typedef enum logic [2:0] {
        EV_IGNORED    = 3'd0,
        EV_REFRESHED  = 3'd1,
        EV_ACTIVITY   = 3'd2,
        EV_NEW        = 3'd3,
        EV_FLIPFLOP   = 3'd4,
        EV_REUSED     = 3'd5,
        EV_CHANGED    = 3'd6,
        EV_TABLE_FULL = 3'd7
    } event_t;

endpackage

>>> rtl/ip_mac_binding_monitor_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ip_mac_binding_monitor_unit: IPv4 to MAC binding monitor
// Set-associative table of IPs, each with a most-recent-first MAC list.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries ip_addr, mac_addr, timestamp.
//   Output channel (out_valid/out_ready) returns one classification per item.
//   cfg_we/cfg_wdata write new_activity_delta; write only while idle.
// Timing:
//   One item at a time. After the input transfer the bucket probe issues one
//   way per cycle into the entry memory, then the entry is picked, the list is
//   read through the slot memory, the new list is built, up to MACS_PER_IP
//   words are written back, the entry is written (new IP or changed MAC only)
//   and the output is loaded. A full bucket goes to the output load after the
//   probe, a zero IP at once. The next item can be taken from the cycle after
//   the result transfer.
// Reset:
//   Reset clears control state, then a clearing pass walks the entry memory,
//   one entry per cycle; no item is taken meanwhile.
// Stall:
//   The result waits in the output register; the next item is taken only
//   once the result has been transferred.
// ---------------------------------------------------------------------------
module ip_mac_binding_monitor_unit #(
    parameter int unsigned BUCKETS     = imbm_pkg::BUCKETS_DEF,
    parameter int unsigned WAYS        = imbm_pkg::WAYS_DEF,
    parameter int unsigned MACS_PER_IP = imbm_pkg::MACS_PER_IP_DEF,
    parameter int unsigned TIME_BITS   = imbm_pkg::TIME_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] ip_addr,
    input  logic [47:0] mac_addr,
    input  logic [31:0] timestamp,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_res,
    output logic [47:0] prev_mac,
    output logic [31:0] prev_time,
    output logic        recheck_name,
    output logic        dropped_oldest
);
    import imbm_pkg::*;

    localparam int unsigned ENTRIES = BUCKETS * WAYS;
    localparam int unsigned SLOTS   = ENTRIES * MACS_PER_IP;
    localparam int unsigned EW      = $clog2(ENTRIES);
    localparam int unsigned SW      = $clog2(SLOTS);
    localparam int unsigned WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned MW      = $clog2(MACS_PER_IP + 1);
    localparam int unsigned LW      = $clog2(MACS_PER_IP);
    localparam int unsigned TB      = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam logic [31:0] TMASK   = 32'hFFFF_FFFF >> (32 - TB);

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_PROBE  = 9'b000000100,
        ST_PDONE  = 9'b000001000,
        ST_LREAD  = 9'b000010000,
        ST_DECIDE = 9'b000100000,
        ST_WRITE  = 9'b001000000,
        ST_EWRITE = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    // entry word: valid, ip, count
    typedef struct packed {
        logic          valid;
        logic [31:0]   ip;
        logic [MW-1:0] cnt;
    } entry_t;

    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] tm;
    } slot_t;

    entry_t entry_mem [ENTRIES];
    slot_t  slot_mem  [SLOTS];

    logic          e_we;
    logic [EW-1:0] e_waddr, e_raddr;
    entry_t        e_wdata, e_rdata;
    logic          s_we;
    logic [SW-1:0] s_waddr, s_raddr;
    slot_t         s_wdata, s_rdata;

    always_ff @(posedge clk)
    begin
        if (e_we)
            entry_mem[e_waddr] <= e_wdata;
        e_rdata <= entry_mem[e_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
            slot_mem[s_waddr] <= s_wdata;
        s_rdata <= slot_mem[s_raddr];
    end

    state_t        state_reg, state_next;
    logic [EW:0]   clr_reg, clr_next;
    logic [31:0]   delta_reg;
    logic [31:0]   ip_reg;
    logic [47:0]   mac_reg;
    logic [31:0]   ts_reg;
    logic [WW:0]   way_reg, way_next;     // way being issued
    logic          rd_pend_reg, rd_pend_next;
    logic [WW-1:0] rd_way_reg, rd_way_next;
    logic          found_reg, found_next;
    logic          free_reg, free_next;
    logic [WW-1:0] fway_reg, fway_next;
    logic [WW-1:0] eway_reg, eway_next;
    logic [MW-1:0] cnt_reg, cnt_next;
    slot_t         list_reg [MACS_PER_IP];
    logic [MW-1:0] li_reg, li_next;       // list read issue index
    logic [MW-1:0] lr_reg, lr_next;       // list read receive index
    slot_t         new_reg  [MACS_PER_IP];
    logic [MW-1:0] wlen_reg, wlen_next;
    logic [MW-1:0] wi_reg, wi_next;
    logic [MW-1:0] ncnt_reg, ncnt_next;
    logic          ewr_reg, ewr_next;
    logic          ovalid_reg, ovalid_next;
    event_t        ev_reg, ev_next;
    logic [47:0]   pmac_reg, pmac_next;
    logic [31:0]   ptime_reg, ptime_next;
    logic          rc_reg, rc_next;
    logic          dr_reg, dr_next;

    logic [EW-1:0] bucket_base;
    logic [EW-1:0] entry_sel;

    assign bucket_base = EW'((ip_reg % BUCKETS) * WAYS);
    assign entry_sel   = bucket_base + EW'(found_reg ? eway_reg : fway_reg);

    // hit search and time difference over the captured list
    logic [MW-1:0] hit_idx;
    logic          hit_any;
    logic [31:0]   tdiff;

    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = MACS_PER_IP - 1; i >= 1; i--)
        begin
            if (MW'(i) < cnt_reg && list_reg[i].mac == mac_reg)
            begin
                hit_any = 1'b1;
                hit_idx = MW'(i);
            end
        end
        tdiff = ts_reg - list_reg[0].tm;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            delta_reg   <= DELTA_RESET;
            ovalid_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            ovalid_reg  <= ovalid_next;
            rd_pend_reg <= rd_pend_next;
            if (cfg_we)
                delta_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ip_reg  <= ip_addr;
            mac_reg <= mac_addr;
            ts_reg  <= timestamp & TMASK;
        end
        way_reg   <= way_next;
        rd_way_reg <= rd_way_next;
        found_reg <= found_next;
        free_reg  <= free_next;
        fway_reg  <= fway_next;
        eway_reg  <= eway_next;
        cnt_reg   <= cnt_next;
        li_reg    <= li_next;
        lr_reg    <= lr_next;
        wlen_reg  <= wlen_next;
        wi_reg    <= wi_next;
        ncnt_reg  <= ncnt_next;
        ewr_reg   <= ewr_next;
        ev_reg    <= ev_next;
        pmac_reg  <= pmac_next;
        ptime_reg <= ptime_next;
        rc_reg    <= rc_next;
        dr_reg    <= dr_next;
        // capture list words as they return
        if (state_reg == ST_LREAD && lr_reg < li_reg)
            list_reg[lr_reg[LW-1:0]] <= s_rdata;
        // build the rewritten list: current MAC and time at front, shift the rest
        if (state_reg == ST_DECIDE)
        begin
            for (int k = 0; k < MACS_PER_IP; k++)
            begin
                if (k == 0)
                    new_reg[k] <= '{mac: mac_reg, tm: ts_reg};
                else
                    new_reg[k] <= list_reg[k - 1];
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        way_next     = way_reg;
        rd_pend_next = 1'b0;
        rd_way_next  = rd_way_reg;
        found_next   = found_reg;
        free_next    = free_reg;
        fway_next    = fway_reg;
        eway_next    = eway_reg;
        cnt_next     = cnt_reg;
        li_next      = li_reg;
        lr_next      = lr_reg;
        wlen_next    = wlen_reg;
        wi_next      = wi_reg;
        ncnt_next    = ncnt_reg;
        ewr_next     = ewr_reg;
        ovalid_next  = ovalid_reg;
        ev_next      = ev_reg;
        pmac_next    = pmac_reg;
        ptime_next   = ptime_reg;
        rc_next      = rc_reg;
        dr_next      = dr_reg;
        e_we    = 1'b0;
        e_waddr = entry_sel;
        e_wdata = '{valid: 1'b1, ip: ip_reg, cnt: ncnt_reg};
        e_raddr = bucket_base + EW'(way_reg[WW-1:0]);
        s_we    = 1'b0;
        s_waddr = SW'(entry_sel) * SW'(MACS_PER_IP) + SW'(wi_reg);
        s_wdata = new_reg[wi_reg[LW-1:0]];
        s_raddr = SW'(entry_sel) * SW'(MACS_PER_IP) + SW'(li_reg);
        in_ready = 1'b0;

        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // invalidate every entry, one per cycle
                e_we    = 1'b1;
                e_waddr = clr_reg[EW-1:0];
                e_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (EW+1)'(ENTRIES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = !ovalid_reg;
                if (in_valid && !ovalid_reg)
                begin
                    way_next   = '0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    rc_next    = 1'b0;
                    dr_next    = 1'b0;
                    pmac_next  = '0;
                    ptime_next = '0;
                    ewr_next   = 1'b0;
                    if (ip_addr == '0)
                    begin
                        ev_next    = EV_IGNORED;
                        state_next = ST_OUT;
                    end
                    else
                        state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                // issue one way per cycle, check the way read last cycle
                if (way_reg < (WW+1)'(WAYS))
                begin
                    rd_pend_next = 1'b1;
                    rd_way_next  = way_reg[WW-1:0];
                    way_next     = way_reg + 1'b1;
                end
                if (rd_pend_reg)
                begin
                    if (e_rdata.valid)
                    begin
                        if (!found_reg && e_rdata.ip == ip_reg)
                        begin
                            found_next = 1'b1;
                            eway_next  = rd_way_reg;
                            cnt_next   = (e_rdata.cnt > MW'(MACS_PER_IP)) ?
                                         MW'(MACS_PER_IP) : e_rdata.cnt;
                        end
                    end
                    else if (!free_reg)
                    begin
                        free_next = 1'b1;
                        fway_next = rd_way_reg;
                    end
                end
                if (way_reg == (WW+1)'(WAYS) && !rd_pend_reg)
                    state_next = ST_PDONE;
            end
            ST_PDONE:
            begin
                li_next = '0;
                lr_next = '0;
                if (found_reg)
                    state_next = ST_LREAD;
                else if (free_reg)
                begin
                    // claim the free way with an empty list
                    cnt_next  = '0;
                    wlen_next = MW'(1);
                    wi_next   = '0;
                    ncnt_next = MW'(1);
                    ewr_next  = 1'b1;
                    ev_next   = EV_NEW;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    ev_next    = EV_TABLE_FULL;
                    state_next = ST_OUT;
                end
            end
            ST_LREAD:
            begin
                if (li_reg < cnt_reg)
                    li_next = li_reg + 1'b1;
                if (lr_reg < li_reg)
                    lr_next = lr_reg + 1'b1;
                if (lr_reg == cnt_reg && li_reg == cnt_reg)
                begin
                    wi_next   = '0;
                    ncnt_next = cnt_reg;
                    ewr_next  = 1'b0;
                    if (list_reg[0].mac == mac_reg)
                    begin
                        wlen_next = MW'(1);
                        if (ts_reg > list_reg[0].tm && tdiff > delta_reg)
                        begin
                            ev_next    = EV_ACTIVITY;
                            ptime_next = list_reg[0].tm;
                            rc_next    = 1'b1;
                        end
                        else
                            ev_next = EV_REFRESHED;
                    end
                    else
                    begin
                        pmac_next  = list_reg[0].mac;
                        ptime_next = list_reg[0].tm;
                        if (hit_any)
                        begin
                            ev_next   = (hit_idx == MW'(1)) ? EV_FLIPFLOP : EV_REUSED;
                            rc_next   = 1'b1;
                            wlen_next = hit_idx + 1'b1;
                        end
                        else
                        begin
                            ev_next = EV_CHANGED;
                            ewr_next = 1'b1;
                            if (cnt_reg >= MW'(MACS_PER_IP))
                            begin
                                dr_next   = 1'b1;
                                wlen_next = cnt_reg;
                            end
                            else
                            begin
                                wlen_next = cnt_reg + 1'b1;
                                ncnt_next = cnt_reg + 1'b1;
                            end
                        end
                    end
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
                state_next = ST_WRITE;
            ST_WRITE:
            begin
                s_we    = 1'b1;
                wi_next = wi_reg + 1'b1;
                if (wi_reg + 1'b1 == wlen_reg)
                    state_next = ewr_reg ? ST_EWRITE : ST_OUT;
            end
            ST_EWRITE:
            begin
                e_we       = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                ovalid_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid      = ovalid_reg;
    assign event_res      = ev_reg;
    assign prev_mac       = pmac_reg;
    assign prev_time      = ptime_reg;
    assign recheck_name   = rc_reg;
    assign dropped_oldest = dr_reg;

endmodule

>>> tb/ip_mac_binding_monitor_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ip_mac_binding_monitor_unit_test: self-checking bench for the binding monitor
// Drives IP/MAC/time observations through the valid/ready input channel,
// predicts each classification with a behavioral copy of the bucket table and
// compares every output transfer field by field, across several settings of
// the activity gap and several idling phases on both channels.
// ---------------------------------------------------------------------------
module ip_mac_binding_monitor_unit_test;

    import imbm_pkg::*;

    localparam int unsigned NB      = BUCKETS_DEF;
    localparam int unsigned NW      = WAYS_DEF;
    localparam int unsigned NM      = MACS_PER_IP_DEF;
    localparam int          WDOG    = 20000;  // covers the clearing pass too
    localparam int          N_PHASE = 5;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] ts;
    } sighting_t;

    typedef struct packed {
        event_t      ev;
        logic [47:0] pmac;
        logic [31:0] ptime;
        logic        recheck;
        logic        dropped;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] ip_addr = '0;
    logic [47:0] mac_addr = '0;
    logic [31:0] timestamp = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  event_res;
    logic [47:0] prev_mac;
    logic [31:0] prev_time;
    logic        recheck_name;
    logic        dropped_oldest;

    ip_mac_binding_monitor_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .ip_addr        (ip_addr),
        .mac_addr       (mac_addr),
        .timestamp      (timestamp),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .prev_mac       (prev_mac),
        .prev_time      (prev_time),
        .recheck_name   (recheck_name),
        .dropped_oldest (dropped_oldest)
    );

    always #5 clk = ~clk;

    // Shadow of the binding table
    logic        sh_valid [NB*NW];
    logic [31:0] sh_ip    [NB*NW];
    int          sh_count [NB*NW];
    logic [47:0] sh_mac   [NB*NW][NM];
    logic [31:0] sh_seen  [NB*NW][NM];
    logic [31:0] activity_gap;

    sighting_t pending_sightings[$];
    verdict_t  expected_verdicts[$];

    int  mismatches = 0;
    int  idle_pct = 0;      // sender idle percentage for the current phase
    int  stall_pct = 0;     // receiver stall percentage for the current phase
    int  quiet_cycles = 0;
    bit  hold_sender = 1'b0;

    // Move list slots 0..n-1 back one place and put (mac, t) at the front.
    function automatic void shift_in(int e, int n, logic [47:0] m, logic [31:0] t);
        for (int k = n; k > 0; k--) begin
            sh_mac[e][k]  = sh_mac[e][k-1];
            sh_seen[e][k] = sh_seen[e][k-1];
        end
        sh_mac[e][0]  = m;
        sh_seen[e][0] = t;
    endfunction

    function automatic verdict_t classify_sighting(sighting_t s);
        verdict_t v;
        int       bkt, e, hit, free_e, n, i;
        v = '{ev: EV_IGNORED, pmac: '0, ptime: '0, recheck: 1'b0, dropped: 1'b0};
        if (s.ip == 0)
            return v;
        bkt = s.ip % NB;
        hit = -1;
        free_e = -1;
        for (int w = 0; w < NW; w++) begin
            e = bkt * NW + w;
            if (sh_valid[e]) begin
                if (hit < 0 && sh_ip[e] == s.ip)
                    hit = e;
            end else if (free_e < 0) begin
                free_e = e;
            end
        end
        if (hit < 0 && free_e >= 0) begin
            hit = free_e;
            sh_valid[hit] = 1'b1;
            sh_ip[hit]    = s.ip;
            sh_count[hit] = 0;
        end
        if (hit < 0) begin
            v.ev = EV_TABLE_FULL;
            return v;
        end
        e = hit;
        n = sh_count[e];
        if (n == 0) begin
            sh_mac[e][0]  = s.mac;
            sh_seen[e][0] = s.ts;
            sh_count[e]   = 1;
            v.ev = EV_NEW;
        end else if (sh_mac[e][0] == s.mac) begin
            if (s.ts > sh_seen[e][0] && (s.ts - sh_seen[e][0]) > activity_gap) begin
                v.ev = EV_ACTIVITY;
                v.ptime = sh_seen[e][0];
                v.recheck = 1'b1;
            end else begin
                v.ev = EV_REFRESHED;
            end
            sh_seen[e][0] = s.ts;
        end else begin
            v.pmac  = sh_mac[e][0];
            v.ptime = sh_seen[e][0];
            for (i = 1; i < n; i++)
                if (sh_mac[e][i] == s.mac)
                    break;
            if (i < n) begin
                v.ev = (i == 1) ? EV_FLIPFLOP : EV_REUSED;
                v.recheck = 1'b1;
                shift_in(e, i, s.mac, s.ts);
            end else begin
                v.ev = EV_CHANGED;
                if (n >= NM) begin
                    v.dropped = 1'b1;
                    shift_in(e, n - 1, s.mac, s.ts);
                end else begin
                    shift_in(e, n, s.mac, s.ts);
                    sh_count[e] = n + 1;
                end
            end
        end
        return v;
    endfunction

    // Driver: pop the next sighting into the port, hold it until transferred.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (pending_sightings.size() > 0 && !hold_sender &&
                    $urandom_range(99) >= idle_pct)
                begin
                    sighting_t s;
                    s = pending_sightings.pop_front();
                    expected_verdicts.push_back(classify_sighting(s));
                    in_valid  <= 1'b1;
                    ip_addr   <= s.ip;
                    mac_addr  <= s.mac;
                    timestamp <= s.ts;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor: check each output transfer against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: ev=%0d", event_res);
                end
                else
                begin
                    verdict_t x;
                    x = expected_verdicts.pop_front();
                    if (event_res !== x.ev || prev_mac !== x.pmac ||
                        prev_time !== x.ptime || recheck_name !== x.recheck ||
                        dropped_oldest !== x.dropped)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp ev=%0d mac=%h t=%h rc=%b dr=%b / got ev=%0d mac=%h t=%h rc=%b dr=%b",
                                     x.ev, x.pmac, x.ptime, x.recheck, x.dropped,
                                     event_res, prev_mac, prev_time, recheck_name,
                                     dropped_oldest);
                    end
                end
            end
            if (quiet_cycles >= WDOG)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // IPs drawn from a few crowded buckets so that lists and buckets fill up.
    function automatic logic [31:0] pick_ip();
        logic [31:0] hi;
        int          r;
        r = $urandom_range(99);
        if (r < 3)
            return 32'h0;
        if (r < 8)
            return $urandom;
        hi = $urandom_range(5);
        if (r < 12)
            hi = $urandom_range(1 << 21, (1 << 22) - 1);
        return {hi[21:0], 10'($urandom_range(7) * 131)};
    endfunction

    function automatic logic [47:0] pick_mac();
        if ($urandom_range(99) < 10)
            return {$urandom, 16'($urandom)};
        return {40'hA0_0000_0000 | 40'($urandom_range(3) << 20),
                8'($urandom_range(5))} ^ {48{$urandom_range(9) == 0}};
    endfunction

    task automatic add_sighting(logic [31:0] ip, logic [47:0] mac, logic [31:0] ts);
        pending_sightings.push_back('{ip: ip, mac: mac, ts: ts});
    endtask

    // Wait until every prediction has been checked, then let the block settle.
    task automatic drain();
        while (pending_sightings.size() > 0 || expected_verdicts.size() > 0 || in_valid)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_gap(logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        activity_gap = val;
    endtask

    initial
    begin
        logic [31:0] clock_s;
        logic [31:0] gaps [N_PHASE];
        for (int e = 0; e < NB*NW; e++)
        begin
            sh_valid[e] = 1'b0;
            sh_count[e] = 0;
        end
        activity_gap = DELTA_RESET;
        gaps = '{32'd100, 32'd0, 32'hFFFF_FFFF, 32'd5, 32'h8000_0000};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every event class at the reset gap.
        add_sighting(32'h0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);      // ignored
        add_sighting(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd0);      // new
        add_sighting(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd10);     // refreshed
        add_sighting(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd5);      // time backwards
        add_sighting(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF); // activity
        add_sighting(32'h0000_0401, 48'h0, 32'd1);                  // new, mac zero
        add_sighting(32'h0000_0401, 48'h1, 32'd2);                  // changed
        add_sighting(32'h0000_0401, 48'h0, 32'd3);                  // flipflop
        add_sighting(32'h0000_0401, 48'h2, 32'd4);                  // changed
        add_sighting(32'h0000_0401, 48'h3, 32'd5);                  // changed, list full
        add_sighting(32'h0000_0401, 48'h4, 32'd6);                  // changed, drop oldest
        add_sighting(32'h0000_0401, 48'h2, 32'd7);                  // reused
        add_sighting(32'h0000_0401, 48'h0, 32'd8);                  // reused, still in list
        add_sighting(32'h0000_0001, 48'h5, 32'd9);                  // same bucket ways
        add_sighting(32'h0000_0801, 48'h6, 32'd9);
        add_sighting(32'h0000_0C01, 48'h7, 32'd9);
        add_sighting(32'h0000_1001, 48'h8, 32'd9);                  // table full
        add_sighting(32'h0000_0001, 48'h5, 32'd10);
        add_sighting(32'h8000_0000, 48'h8000_0000_0000, 32'h8000_0000);
        drain();

        // Hold the sender back with a sighting queued, then resume.
        hold_sender = 1'b1;
        add_sighting(32'h0000_0401, 48'h3, 32'd20);
        repeat (50) @(posedge clk);
        hold_sender = 1'b0;
        drain();

        clock_s = 32'd1000;
        for (int ph = 0; ph < N_PHASE; ph++)
        begin
            write_gap(gaps[ph]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 85; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            for (int k = 0; k < 150; k++)
            begin
                int j;
                j = $urandom_range(99);
                if (j < 5)
                    clock_s = $urandom;
                else if (j < 15)
                    clock_s = clock_s - $urandom_range(50);
                else if (j < 25)
                    clock_s = clock_s + $urandom;
                else
                    clock_s = clock_s + $urandom_range(200);
                add_sighting(pick_ip(), pick_mac(), clock_s);
            end
            drain();
        end

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
